### rtl/dht_pkg.sv
`timescale 1ns / 1ps
package dht_pkg;

    localparam int SIZE_W = 11;
    localparam int STEP_W = 10;
    localparam int HASH_W = 64;
    localparam int VAL_W  = 32;

    localparam logic [HASH_W-1:0] HASH_SEED     = 64'd5381;
    localparam logic [SIZE_W-1:0] SIZE_RESET    = 11'd1021;
    localparam logic [STEP_W-1:0] STEP_RESET    = 10'd1019;

    // configuration register indexes
    localparam logic CFG_TABLE_SIZE = 1'b0;
    localparam logic CFG_STEP_PRIME = 1'b1;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_SPARE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        SLOT_EMPTY = 2'd0,
        SLOT_USED  = 2'd1,
        SLOT_TOMB  = 2'd2,
        SLOT_RSVD  = 2'd3
    } t_slot;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_FOUND    = 3'd2,
        ST_MISSING  = 3'd3,
        ST_DELETED  = 3'd4,
        ST_FULL     = 3'd5,
        ST_TOOLONG  = 3'd6,
        ST_RSVD     = 3'd7
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_COLLECT,
        S_DIV,
        S_STRIDE,
        S_PROBE,
        S_PROBE_CHK,
        S_CMP,
        S_CMP_CHK,
        S_HIT,
        S_HIT_RD,
        S_FINISH,
        S_COPY,
        S_COPY_WR,
        S_COMMIT,
        S_DONE
    } t_state;

endpackage

### rtl/dht_if.sv
`timescale 1ns / 1ps
interface dht_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  key_byte;
    logic        key_last;
    logic signed [31:0] value;

    modport source (output valid, cmd, key_byte, key_last, value, input ready);
    modport sink   (input valid, cmd, key_byte, key_last, value, output ready);
endinterface

interface dht_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic signed [31:0] value_out;
    logic        grow_needed;
    logic [10:0] entry_total;

    modport source (output valid, status, value_out, grow_needed, entry_total, input ready);
    modport sink   (input valid, status, value_out, grow_needed, entry_total, output ready);
endinterface

### rtl/dht_ram.sv
`timescale 1ns / 1ps
module dht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

### rtl/double_hash_string_table.sv
`timescale 1ns / 1ps
// Key bytes are taken one per cycle. After the last byte the 64-step remainder unit (hash mod
// size and mod step prime) runs, then the serial probe/compare sequencer walks the probes,
// compares the stored key bytes on each probe and, on insert, copies the key in, over memories
// with one write port and one registered read port; one key is in flight at a time.
// Reset (synchronous, active low): a clearing pass marks every slot empty, during which no
// request is taken; configuration writes are taken throughout.
module double_hash_string_table #(
    parameter int CAPACITY  = 1024,
    parameter int KEY_BYTES = 48
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_idx,
    input  logic [10:0]     i_cfg_data,
    dht_req_if.sink         i_req,
    dht_rsp_if.source       o_rsp
);
    import dht_pkg::*;

    localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int KAW  = $clog2(CAPACITY * KEY_BYTES);
    localparam int PAW  = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int LW   = $clog2(KEY_BYTES + 1);
    localparam logic [IW-1:0] CLR_LAST = IW'(CAPACITY - 1);
    localparam logic [LW-1:0] KEY_FULL = LW'(KEY_BYTES);

    t_state             r_state, n_state;
    logic [SIZE_W-1:0]  r_tsize;
    logic [STEP_W-1:0]  r_rp;
    logic [IW-1:0]      r_clr;
    logic [HASH_W-1:0]  r_hash;
    logic [LW-1:0]      r_plen;
    logic               r_ovf;
    t_cmd               r_cmd;
    logic [VAL_W-1:0]   r_val;
    logic               r_grow;
    logic [HASH_W-1:0]  r_div;
    logic [6:0]         r_cnt;
    logic [SIZE_W-1:0]  r_rema;
    logic [STEP_W-1:0]  r_remb;
    logic [SIZE_W-1:0]  r_idx;
    logic [SIZE_W-1:0]  r_stride;
    logic [SIZE_W-1:0]  r_att;
    logic [SIZE_W-1:0]  r_tomb;
    logic               r_have_tomb;
    logic               r_have_free;
    logic [KAW-1:0]     r_base;
    logic [LW-1:0]      r_j;
    t_status            r_status;
    logic [VAL_W-1:0]   r_vout;
    logic [SIZE_W-1:0]  r_count;
    logic               r_out_valid;
    t_status            r_out_status;
    logic [VAL_W-1:0]   r_out_value;
    logic               r_out_grow;
    logic [SIZE_W-1:0]  r_out_total;

    logic [SIZE_W-1:0]  size;
    logic [STEP_W-1:0]  rp;
    logic               accept;
    logic               out_free;
    logic [SIZE_W:0]    ta;
    logic [STEP_W:0]    tb;
    logic [SIZE_W-1:0]  rema_nx;
    logic [STEP_W-1:0]  remb_nx;
    logic [SIZE_W-1:0]  diff;
    logic [SIZE_W:0]    idx_sum;
    logic [SIZE_W-1:0]  idx_adv;
    logic               probe_end;
    logic               len_eq;
    logic               byte_eq;
    logic               byte_last;
    logic [IW-1:0]      slot_addr;
    logic [KAW-1:0]     key_addr;

    logic               st_we;
    logic [IW-1:0]      st_waddr;
    logic [1:0]         st_wdata;
    logic [1:0]         st_q;
    t_slot              slot_q;
    logic               len_we;
    logic [LW-1:0]      len_q;
    logic               val_we;
    logic [VAL_W-1:0]   val_q;
    logic               key_we;
    logic [7:0]         key_q;
    logic               pend_we;
    logic [7:0]         pend_q;

    // effective size and step prime
    always_comb begin
        size = r_tsize;
        if (32'(r_tsize) > CAPACITY) begin
            size = SIZE_W'(CAPACITY);
        end
        if (size == '0) begin
            size = SIZE_W'(1);
        end
        rp = (r_rp == '0) ? STEP_W'(1) : r_rp;
    end

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;

    // shared remainder step, one dividend bit per cycle
    always_comb begin
        ta = {r_rema, r_div[HASH_W-1]};
        if (ta >= {1'b0, size}) begin
            ta = ta - {1'b0, size};
        end
        tb = {r_remb, r_div[HASH_W-1]};
        if (tb >= {1'b0, rp}) begin
            tb = tb - {1'b0, rp};
        end
        rema_nx = ta[SIZE_W-1:0];
        remb_nx = tb[STEP_W-1:0];
        diff    = SIZE_W'(rp) - SIZE_W'(remb_nx);
    end

    // probe advance and compare terms
    assign idx_sum   = {1'b0, r_idx} + {1'b0, r_stride};
    assign idx_adv   = (idx_sum >= {1'b0, size}) ? SIZE_W'(idx_sum - {1'b0, size})
                                                 : idx_sum[SIZE_W-1:0];
    assign probe_end = (r_att == size);
    assign slot_q    = t_slot'(st_q);
    assign len_eq    = (len_q == r_plen);
    assign byte_eq   = (key_q == pend_q);
    assign byte_last = (r_j == r_plen - LW'(1));
    assign slot_addr = IW'(r_idx);
    assign key_addr  = r_base + KAW'(r_j);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:     if (r_clr == CLR_LAST) n_state = S_COLLECT;
            S_COLLECT: begin
                if (accept && i_req.key_last) begin
                    n_state = (r_ovf || r_plen == KEY_FULL) ? S_DONE : S_DIV;
                end
            end
            S_DIV:       if (r_cnt == '0) n_state = S_STRIDE;
            S_STRIDE:    if (r_cnt == '0) n_state = S_PROBE;
            S_PROBE:     n_state = probe_end ? S_FINISH : S_PROBE_CHK;
            S_PROBE_CHK: begin
                case (slot_q)
                    SLOT_EMPTY: n_state = S_FINISH;
                    SLOT_USED:  n_state = len_eq ? S_CMP : S_PROBE;
                    default:    n_state = S_PROBE;
                endcase
            end
            S_CMP:       n_state = S_CMP_CHK;
            S_CMP_CHK: begin
                if (!byte_eq)      n_state = S_PROBE;
                else if (byte_last) n_state = S_HIT;
                else               n_state = S_CMP;
            end
            S_HIT: begin
                n_state = (r_cmd == CMD_INSERT || r_cmd == CMD_DELETE) ? S_DONE : S_HIT_RD;
            end
            S_HIT_RD:    n_state = S_DONE;
            S_FINISH: begin
                n_state = (r_cmd == CMD_INSERT && (r_have_tomb || r_have_free)) ? S_COPY
                                                                                 : S_DONE;
            end
            S_COPY:      n_state = S_COPY_WR;
            S_COPY_WR:   n_state = byte_last ? S_COMMIT : S_COPY;
            S_COMMIT:    n_state = S_DONE;
            S_DONE:      if (out_free) n_state = S_COLLECT;
            default:     n_state = S_COLLECT;
        endcase
    end

    // memory controls and request ready
    always_comb begin
        i_req.ready = (r_state == S_COLLECT);
        st_we    = 1'b0;
        st_waddr = slot_addr;
        st_wdata = SLOT_EMPTY;
        len_we   = 1'b0;
        val_we   = 1'b0;
        key_we   = 1'b0;
        pend_we  = accept && (r_plen != KEY_FULL);
        case (r_state)
            S_CLEAR: begin
                st_we    = 1'b1;
                st_waddr = r_clr;
            end
            S_HIT: begin
                if (r_cmd == CMD_INSERT) begin
                    val_we = 1'b1;
                end else if (r_cmd == CMD_DELETE) begin
                    st_we    = 1'b1;
                    st_wdata = SLOT_TOMB;
                end
            end
            S_COPY_WR: key_we = 1'b1;
            S_COMMIT: begin
                len_we   = 1'b1;
                val_we   = 1'b1;
                st_we    = 1'b1;
                st_wdata = SLOT_USED;
            end
            default: ;
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_tsize     <= SIZE_RESET;
            r_rp        <= STEP_RESET;
            r_hash      <= HASH_SEED;
            r_plen      <= '0;
            r_ovf       <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TABLE_SIZE: r_tsize <= i_cfg_data;
                    CFG_STEP_PRIME: r_rp    <= i_cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + IW'(1);
            end
            // collect key bytes
            if (accept) begin
                r_hash <= (r_hash << 5) + r_hash + HASH_W'(i_req.key_byte);
                if (r_plen != KEY_FULL) begin
                    r_plen <= r_plen + LW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (r_state == S_HIT && r_cmd == CMD_DELETE) begin
                r_count <= r_count - SIZE_W'(1);
            end
            if (r_state == S_COMMIT) begin
                r_count <= r_count + SIZE_W'(1);
            end
            // hand over result and drop the pending key
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
                r_hash      <= HASH_SEED;
                r_plen      <= '0;
                r_ovf       <= 1'b0;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_COLLECT: begin
                if (accept && i_req.key_last) begin
                    r_cmd    <= t_cmd'(i_req.cmd);
                    r_val    <= i_req.value;
                    r_div    <= (r_hash << 5) + r_hash + HASH_W'(i_req.key_byte);
                    r_cnt    <= 7'(HASH_W - 1);
                    r_rema   <= '0;
                    r_remb   <= '0;
                    r_vout   <= '0;
                    r_status <= ST_TOOLONG;
                    r_grow   <= (t_cmd'(i_req.cmd) == CMD_INSERT) &&
                                !(r_ovf || r_plen == KEY_FULL) &&
                                ({r_count, 2'b00} >= 13'(size) * 13'd3);
                end
            end
            S_DIV: begin
                r_remb <= remb_nx;
                if (r_cnt == '0) begin
                    r_idx  <= rema_nx;
                    r_rema <= '0;
                    r_div  <= {diff, (HASH_W - SIZE_W)'(0)};
                    r_cnt  <= 7'(SIZE_W - 1);
                end else begin
                    r_rema <= rema_nx;
                    r_div  <= r_div << 1;
                    r_cnt  <= r_cnt - 7'd1;
                end
            end
            S_STRIDE: begin
                r_rema <= rema_nx;
                r_div  <= r_div << 1;
                r_cnt  <= r_cnt - 7'd1;
                if (r_cnt == '0) begin
                    r_stride    <= rema_nx;
                    r_att       <= '0;
                    r_have_tomb <= 1'b0;
                    r_have_free <= 1'b0;
                end
            end
            S_PROBE: begin
                r_base <= KAW'(32'(r_idx) * KEY_BYTES);
                r_j    <= '0;
            end
            S_PROBE_CHK: begin
                case (slot_q)
                    SLOT_EMPTY: r_have_free <= 1'b1;
                    SLOT_USED: begin
                        if (!len_eq) begin
                            r_idx <= idx_adv;
                            r_att <= r_att + SIZE_W'(1);
                        end
                    end
                    default: begin
                        if (!r_have_tomb) begin
                            r_tomb      <= r_idx;
                            r_have_tomb <= 1'b1;
                        end
                        r_idx <= idx_adv;
                        r_att <= r_att + SIZE_W'(1);
                    end
                endcase
            end
            S_CMP_CHK: begin
                if (!byte_eq) begin
                    r_idx <= idx_adv;
                    r_att <= r_att + SIZE_W'(1);
                end else if (!byte_last) begin
                    r_j <= r_j + LW'(1);
                end
            end
            S_HIT: begin
                case (r_cmd)
                    CMD_INSERT: r_status <= ST_UPDATED;
                    CMD_DELETE: r_status <= ST_DELETED;
                    default:    r_status <= ST_FOUND;
                endcase
            end
            S_HIT_RD: r_vout <= val_q;
            S_FINISH: begin
                r_status <= (r_cmd == CMD_INSERT) ? ST_FULL : ST_MISSING;
                r_idx    <= r_have_tomb ? r_tomb : r_idx;
                r_base   <= KAW'(32'(r_have_tomb ? r_tomb : r_idx) * KEY_BYTES);
                r_j      <= '0;
            end
            S_COPY_WR: if (!byte_last) r_j <= r_j + LW'(1);
            S_COMMIT:  r_status <= ST_INSERTED;
            S_DONE: begin
                if (out_free) begin
                    r_out_status <= r_status;
                    r_out_value  <= r_vout;
                    r_out_grow   <= r_grow;
                    r_out_total  <= r_count;
                end
            end
            default: ;
        endcase
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.value_out   = r_out_value;
    assign o_rsp.grow_needed = r_out_grow;
    assign o_rsp.entry_total = r_out_total;

    dht_ram #(.WIDTH(2), .DEPTH(CAPACITY)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (slot_addr),
        .o_rdata (st_q)
    );

    dht_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (slot_addr),
        .i_wdata (r_plen),
        .i_raddr (slot_addr),
        .o_rdata (len_q)
    );

    dht_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (slot_addr),
        .i_wdata (r_val),
        .i_raddr (slot_addr),
        .o_rdata (val_q)
    );

    dht_ram #(.WIDTH(8), .DEPTH(CAPACITY * KEY_BYTES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_addr),
        .i_wdata (pend_q),
        .i_raddr (key_addr),
        .o_rdata (key_q)
    );

    dht_ram #(.WIDTH(8), .DEPTH(KEY_BYTES)) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (pend_we),
        .i_waddr (PAW'(r_plen)),
        .i_wdata (i_req.key_byte),
        .i_raddr (PAW'(r_j)),
        .o_rdata (pend_q)
    );

`ifndef SYNTHESIS
    a_commit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) |=> (r_count == $past(r_count) + SIZE_W'(1)))
        else $error("insert commit did not raise the entry count");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result presented outside the done step");

    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_idx < size && r_stride < size))
        else $error("probe slot or step beyond table size");

    a_clear_then_collect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && r_clr == CLR_LAST) |=> (r_state == S_COLLECT))
        else $error("clearing pass did not end in collect");
`endif

endmodule

### test/tb_double_hash_string_table.sv
`timescale 1ns / 1ps
module tb_double_hash_string_table;
    import dht_pkg::*;

    localparam int CAP       = 1024;
    localparam int KEYMAX    = 48;
    localparam int IDLE_WAIT = 400;
    localparam int WDOG_MAX  = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = 1'b0;
    logic [10:0] i_cfg_data = '0;

    dht_req_if req_bus ();
    dht_rsp_if rsp_bus ();

    double_hash_string_table #(.CAPACITY(CAP), .KEY_BYTES(KEYMAX)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_bus.sink),
        .o_rsp      (rsp_bus.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    typedef struct packed {
        t_status     status;
        logic [31:0] value_out;
        logic        grow_needed;
        logic [10:0] entry_total;
    } t_outcome;

    // Table model plus queue of predicted outcomes
    class table_scoreboard;
        logic [10:0] size_reg;
        logic [9:0]  prime_reg;
        t_slot       state_q[CAP];
        byte         keys_q[CAP][$];
        logic [31:0] vals_q[CAP];
        int          live;
        byte         key_buf[$];
        logic [63:0] hash;
        bit          overflow;
        t_outcome    pending_q[$];
        int          errors;

        function void init();
            size_reg = SIZE_RESET;
            prime_reg = STEP_RESET;
            foreach (state_q[i]) state_q[i] = SLOT_EMPTY;
            live = 0;
            key_buf.delete();
            hash = HASH_SEED;
            overflow = 0;
            errors = 0;
        endfunction

        function void set_reg(logic idx, logic [10:0] data);
            if (idx == CFG_TABLE_SIZE) size_reg = data;
            else prime_reg = data[9:0];
        endfunction

        function bit same_key(int s);
            if (keys_q[s].size() != key_buf.size()) return 0;
            foreach (key_buf[i]) if (keys_q[s][i] != key_buf[i]) return 0;
            return 1;
        endfunction

        // Note one accepted byte; on the last byte run the operation
        function void note_request(t_cmd cmd, logic [7:0] kb, logic last,
                                   logic [31:0] val);
            t_outcome o;
            int sz, rp, idx, stride, tomb, slot;
            bit have_tomb, have_free, done;
            hash = hash * 33 + kb;
            if (key_buf.size() < KEYMAX) key_buf.push_back(kb);
            else overflow = 1;
            if (!last) return;
            o = '0;
            if (overflow) begin
                o.status = ST_TOOLONG;
            end else begin
                sz = (size_reg > CAP) ? CAP : (size_reg == 0 ? 1 : size_reg);
                rp = (prime_reg == 0) ? 1 : prime_reg;
                idx = hash % sz;
                stride = (rp - (hash % rp)) % sz;
                if (cmd == CMD_INSERT) o.grow_needed = (live * 4 >= sz * 3);
                o.status = (cmd == CMD_INSERT) ? ST_FULL : ST_MISSING;
                have_tomb = 0; have_free = 0; done = 0; tomb = 0; slot = 0;
                for (int a = 0; a < sz && !done; a++) begin
                    if (state_q[idx] == SLOT_EMPTY) begin
                        slot = idx; have_free = 1; done = 1;
                    end else if (state_q[idx] == SLOT_USED) begin
                        if (same_key(idx)) begin
                            done = 1;
                            if (cmd == CMD_INSERT) begin
                                vals_q[idx] = val; o.status = ST_UPDATED;
                            end else if (cmd == CMD_DELETE) begin
                                state_q[idx] = SLOT_TOMB; live--; o.status = ST_DELETED;
                            end else begin
                                o.value_out = vals_q[idx]; o.status = ST_FOUND;
                            end
                        end
                    end else if (!have_tomb) begin
                        tomb = idx; have_tomb = 1;
                    end
                    idx += stride;
                    if (idx >= sz) idx -= sz;
                end
                if (cmd == CMD_INSERT && o.status == ST_FULL && (have_tomb || have_free)) begin
                    if (have_tomb) slot = tomb;
                    keys_q[slot] = key_buf;
                    vals_q[slot] = val;
                    state_q[slot] = SLOT_USED;
                    live++;
                    o.status = ST_INSERTED;
                end
            end
            o.entry_total = live;
            pending_q.push_back(o);
            key_buf.delete();
            overflow = 0;
            hash = HASH_SEED;
        endfunction

        function void check_result(t_outcome got);
            t_outcome want;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
                return;
            end
            want = pending_q.pop_front();
            if (got.status !== want.status || got.value_out !== want.value_out ||
                got.grow_needed !== want.grow_needed ||
                got.entry_total !== want.entry_total) begin
                errors++;
                if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
            end
        endfunction
    endclass

    table_scoreboard board = new();
    int idle_cycles = 0;
    bit stim_done = 0;
    int rsp_count = 0;

    initial begin
        req_bus.valid = 1'b0;
        req_bus.cmd = CMD_INSERT;
        req_bus.key_byte = 8'd1;
        req_bus.key_last = 1'b0;
        req_bus.value = '0;
        rsp_bus.ready = 1'b0;
    end

    // Sample both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (req_bus.valid && req_bus.ready) begin
                board.note_request(t_cmd'(req_bus.cmd), req_bus.key_byte,
                                   req_bus.key_last, req_bus.value);
            end
            if (rsp_bus.valid && rsp_bus.ready) begin
                board.check_result({t_status'(rsp_bus.status), rsp_bus.value_out,
                                    rsp_bus.grow_needed, rsp_bus.entry_total});
                rsp_count++;
            end
        end
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
        return $urandom_range(0, 3);
    endfunction

    // Drain side: random stalls, some stretches fully open
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            rsp_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_bus.valid) @(posedge i_clk);
            if ((rsp_count / 40) % 3 != 0) begin
                gap = pick_gap();
                if (gap > 0) begin
                    @(negedge i_clk);
                    rsp_bus.ready <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
        end
    end

    bit gaps_on = 1;

    // Send one key byte, holding valid until the handshake
    task automatic send_byte(t_cmd cmd, logic [7:0] kb, logic last, logic [31:0] val);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.cmd <= cmd;
        req_bus.key_byte <= kb;
        req_bus.key_last <= last;
        req_bus.value <= val;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_key(t_cmd cmd, byte key[$], logic [31:0] val);
        foreach (key[i]) send_byte(cmd, key[i], i == key.size() - 1, val);
    endtask

    task automatic wait_idle();
        req_bus.valid <= 1'b0;
        while (board.pending_q.size() != 0) @(negedge i_clk);
        repeat (IDLE_WAIT) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [10:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        board.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Key drawn from a small pool so operations hit existing entries
    function automatic void pool_key(int id, ref byte key[$]);
        key.delete();
        for (int i = 0; i <= id % 5; i++) key.push_back(byte'(8'h41 + ((id * 7 + i) % 26)));
        key.push_back(byte'(8'h30 + id / 10));
    endfunction

    task automatic random_phase(int count, int pool);
        byte key[$];
        t_cmd cmd;
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            cmd = (r < 45) ? CMD_INSERT : (r < 70) ? CMD_LOOKUP :
                  (r < 95) ? CMD_DELETE : CMD_SPARE;
            if ($urandom_range(0, 9) == 0) begin
                key.delete();
                for (int i = $urandom_range(1, 52); i > 0; i--)
                    key.push_back(byte'($urandom_range(0, 255)));
            end else begin
                pool_key($urandom_range(0, pool - 1), key);
            end
            send_key(cmd, key, $urandom());
        end
    endtask

    initial begin
        byte key[$];
        board.init();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: tiny table to hit full, tombstones, long keys
        write_reg(CFG_TABLE_SIZE, 11'd3);
        write_reg(CFG_STEP_PRIME, 11'd2);
        for (int i = 0; i < 4; i++) begin
            pool_key(i, key);
            send_key(CMD_INSERT, key, 32'h8000_0000 + i);
        end
        pool_key(0, key); send_key(CMD_INSERT, key, 32'h7fff_ffff);
        pool_key(0, key); send_key(CMD_LOOKUP, key, '0);
        pool_key(1, key); send_key(CMD_DELETE, key, '0);
        pool_key(1, key); send_key(CMD_DELETE, key, '0);
        pool_key(9, key); send_key(CMD_LOOKUP, key, '0);
        pool_key(9, key); send_key(CMD_INSERT, key, 32'hffff_ffff);
        pool_key(2, key); send_key(CMD_SPARE, key, '0);
        key.delete(); repeat (48) key.push_back(8'hff);
        send_key(CMD_INSERT, key, 32'd5);
        key.push_back(8'h00); send_key(CMD_INSERT, key, 32'd6);
        key.delete(); key.push_back(8'h00); send_key(CMD_INSERT, key, 32'd7);
        key.delete(); key.push_back(8'h55); key.push_back(8'haa);
        send_key(CMD_INSERT, key, 32'd8);
        wait_idle();

        // Shrink to size 0 and step zero, then out-of-range size
        write_reg(CFG_TABLE_SIZE, 11'd0);
        write_reg(CFG_STEP_PRIME, 11'd0);
        random_phase(4, 6);
        wait_idle();
        write_reg(CFG_TABLE_SIZE, 11'h7ff);
        write_reg(CFG_STEP_PRIME, 11'h3ff);
        random_phase(8, 30);
        wait_idle();
        write_reg(CFG_TABLE_SIZE, 11'd13);
        write_reg(CFG_STEP_PRIME, 11'd11);
        random_phase(18, 20);
        wait_idle();
        write_reg(CFG_TABLE_SIZE, 11'd31);
        write_reg(CFG_STEP_PRIME, 11'd29);
        gaps_on = 0;
        random_phase(12, 40);
        gaps_on = 1;
        wait_idle();
        write_reg(CFG_TABLE_SIZE, 11'd1024);
        write_reg(CFG_STEP_PRIME, 11'd1021);
        random_phase(14, 60);
        wait_idle();
        write_reg(CFG_TABLE_SIZE, 11'd7);
        write_reg(CFG_STEP_PRIME, 11'd5);
        random_phase(10, 12);
        req_bus.valid <= 1'b0;
        stim_done = 1;
    end

    // Finish when drained, or on watchdog
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (idle_cycles >= WDOG_MAX) begin
                $display("** double_hash_string_table: FAILED **");
                $finish;
            end
            if (stim_done && board.pending_q.size() == 0) begin
                repeat (IDLE_WAIT) @(posedge i_clk);
                if (board.errors == 0 && board.pending_q.size() == 0)
                    $display("** double_hash_string_table: PASSED **");
                else
                    $display("** double_hash_string_table: FAILED **");
                $finish;
            end
        end
    end
endmodule

### sim.f
rtl/dht_pkg.sv
rtl/dht_if.sv
rtl/dht_ram.sv
rtl/double_hash_string_table.sv
test/tb_double_hash_string_table.sv
